### design/lct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types and constants for the LFU cache table.
// ----------------------------------------------------------------------------
package lct_pkg;

  // Data and register widths
  localparam int WORD_W  = 32;
  localparam int CAP_W   = 5;
  localparam int PADDR_W = 3;

  // Capacity register reset value
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Register word index (paddr[2])
  localparam logic REG_CAPACITY = 1'b0;

  // Request kinds
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } state_e;

endpackage

### design/lct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lct_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### design/lfu_cache_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_table_top
// Key-value cache with least-frequently-used replacement, oldest stamp on tie.
// ----------------------------------------------------------------------------
// One request is handled at a time and passes the states idle, scan, drain
// and write: the word is taken in idle, the scan sweeps every slot of the RAM
// through its single read port while key match and victim search run on the
// returned data, drain waits for the last read, and the write-back
// updates the slot and loads the result register. With capacity zero a
// request skips the sweep and goes straight to write-back. A new word can be
// accepted while the previous result still waits in the output register;
// the write-back stalls only while that register is still full. Slots fill
// in index order and are never freed, so slot i holds an entry exactly when
// i is below the occupancy count; the RAM needs no clearing after reset.
// ----------------------------------------------------------------------------
module lfu_cache_table_top #(
  parameter int CACHE_DEPTH = 16,
  parameter int KEY_BITS    = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Request channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic [31:0]                 lookup_key_i,
  input  logic signed [31:0]          write_value_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic signed [31:0]          read_value_o,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lct_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int IDX_W  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int OCC_W  = $clog2(CACHE_DEPTH + 1);
  localparam int W      = lct_pkg::WORD_W;
  localparam int ENT_W  = KEY_BITS + 3 * W;

  // Entry layout: {key, value, use count, stamp}
  localparam int STAMP_LO = 0;
  localparam int CNT_LO   = W;
  localparam int VAL_LO   = 2 * W;
  localparam int KEY_LO   = 3 * W;

  lct_pkg::state_e state_q, state_d;

  logic [lct_pkg::CAP_W-1:0] cap_q;
  logic [OCC_W-1:0]          occ_q;
  logic [W-1:0]              stamp_q;

  // Request registers
  logic                      op_q;
  logic [KEY_BITS-1:0]       key_q;
  logic [W-1:0]              val_q;
  logic                      off_q;

  // Sweep control
  logic [OCC_W-1:0]          scan_cnt_q;
  logic                      rd_vld_q;
  logic [IDX_W-1:0]          rd_idx_q;

  // Search results
  logic                      found_q;
  logic [IDX_W-1:0]          f_idx_q;
  logic [W-1:0]              f_val_q;
  logic [W-1:0]              f_cnt_q;
  logic                      vic_vld_q;
  logic [IDX_W-1:0]          v_idx_q;
  logic [W-1:0]              v_cnt_q;
  logic [W-1:0]              v_stamp_q;

  // Result register
  logic                      out_vld_q;
  logic                      hit_q;
  logic [W-1:0]              rval_q;

  // Control strobes
  logic                      accept;
  logic                      out_load;
  logic                      ram_re;
  logic                      ram_we;
  logic                      last_issue;

  // RAM interface
  logic [IDX_W-1:0]          waddr;
  logic [ENT_W-1:0]          wdata;
  logic [ENT_W-1:0]          rdata;

  // Read data fields
  logic [KEY_BITS-1:0]       r_key;
  logic [W-1:0]              r_val;
  logic [W-1:0]              r_cnt;
  logic [W-1:0]              r_stamp;
  logic                      r_live;

  // Write-back values
  logic                      full;
  logic                      touch;
  logic [W-1:0]              new_cnt;
  logic [W-1:0]              new_val;
  logic [W-1:0]              new_stamp;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lct_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == lct_pkg::REG_CAPACITY) begin
      cap_q <= pwdata[lct_pkg::CAP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == lct_pkg::REG_CAPACITY) ? 32'(cap_q) : 32'd0;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign last_issue = (scan_cnt_q == OCC_W'(CACHE_DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lct_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ram_re     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      lct_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = (cap_q == '0) ? lct_pkg::ST_WRITE : lct_pkg::ST_SCAN;
        end
      end
      lct_pkg::ST_SCAN: begin
        ram_re = 1'b1;
        if (last_issue) begin
          state_d = lct_pkg::ST_DRAIN;
        end
      end
      lct_pkg::ST_DRAIN: begin
        state_d = lct_pkg::ST_WRITE;
      end
      lct_pkg::ST_WRITE: begin
        if (!out_vld_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = lct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lct_pkg::ST_IDLE;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Slot RAM
  // --------------------------------------------------------------------------
  lct_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CACHE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (scan_cnt_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign r_key   = rdata[KEY_LO +: KEY_BITS];
  assign r_val   = rdata[VAL_LO +: W];
  assign r_cnt   = rdata[CNT_LO +: W];
  assign r_stamp = rdata[STAMP_LO +: W];
  assign r_live  = rd_vld_q && (OCC_W'(rd_idx_q) < occ_q);

  // --------------------------------------------------------------------------
  // Request capture, sweep and search
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
      vic_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= ram_re;
      if (accept) begin
        scan_cnt_q <= '0;
        found_q    <= 1'b0;
        vic_vld_q  <= 1'b0;
      end else begin
        if (ram_re) begin
          scan_cnt_q <= scan_cnt_q + OCC_W'(1);
        end
        // first slot holding the key
        if (r_live && !found_q && r_key == key_q) begin
          found_q <= 1'b1;
        end
        // lowest count, then oldest stamp, then lowest index
        if (r_live && (!vic_vld_q || {r_cnt, r_stamp} < {v_cnt_q, v_stamp_q})) begin
          vic_vld_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers of the search
  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_cnt_q[IDX_W-1:0];
    if (accept) begin
      op_q  <= operation_i;
      key_q <= KEY_BITS'(lookup_key_i);
      val_q <= write_value_i;
      off_q <= (cap_q == '0);
    end
    if (r_live && !found_q && r_key == key_q) begin
      f_idx_q <= rd_idx_q;
      f_val_q <= r_val;
      f_cnt_q <= r_cnt;
    end
    if (r_live && (!vic_vld_q || {r_cnt, r_stamp} < {v_cnt_q, v_stamp_q})) begin
      v_idx_q   <= rd_idx_q;
      v_cnt_q   <= r_cnt;
      v_stamp_q <= r_stamp;
    end
  end

  // --------------------------------------------------------------------------
  // Write-back
  // --------------------------------------------------------------------------
  // full when occupancy reaches the capacity, clamped to the depth
  assign full      = (32'(occ_q) >= 32'(cap_q)) || (32'(occ_q) >= 32'(CACHE_DEPTH));
  assign touch     = !off_q && (found_q || op_q == lct_pkg::OP_PUT);
  assign new_stamp = stamp_q + W'(1);
  assign new_cnt   = found_q ? ((f_cnt_q == '1) ? f_cnt_q : f_cnt_q + W'(1)) : W'(1);
  assign new_val   = (found_q && op_q == lct_pkg::OP_GET) ? f_val_q : val_q;
  assign wdata     = {key_q, new_val, new_cnt, new_stamp};
  assign ram_we    = out_load && touch;

  always_comb begin
    if (found_q) begin
      waddr = f_idx_q;
    end else if (full) begin
      waddr = v_idx_q;
    end else begin
      waddr = occ_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      stamp_q <= '0;
    end else if (ram_we) begin
      stamp_q <= new_stamp;
      if (!found_q && !full) begin
        occ_q <= occ_q + OCC_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      hit_q  <= found_q;
      rval_q <= (found_q && op_q == lct_pkg::OP_GET) ? f_val_q : '0;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign hit_o        = hit_q;
  assign read_value_o = rval_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(occ_q) <= 32'(CACHE_DEPTH))
    else $error("occupancy above cache depth");

  a_we_in_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == lct_pkg::ST_WRITE)
    else $error("slot write outside write-back");

  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && !found_q && !full |=> occ_q == $past(occ_q) + OCC_W'(1))
    else $error("fill did not advance occupancy");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> read_value_o == '0)
    else $error("miss with nonzero read value");

  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rd_vld_q && !ram_re)
    else $error("sweep still active while taking a word");

endmodule
